/* sv/ufc_pkg.sv */
// ----------------------------------------------------------------------------
// ufc_pkg
// Shared types, constants and the bytewise crc step of the update frame
// checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ufc_pkg;

  // frame layout and limits
  localparam int unsigned MAX_FRAME_BYTES_DEF = 1024;
  localparam int unsigned MIN_FRAME_BYTES     = 1 + 1 + 2 + 4 + 1;
  localparam int unsigned POS_W               = 17;
  localparam logic [POS_W-1:0] POS_LIMIT      = '1;

  // crc-32, msb first, no final xor
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;

  // configuration register defaults
  localparam logic [7:0] START_MARKER_RST = 8'hAA;
  localparam logic [7:0] END_MARKER_RST   = 8'hBB;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 1'b1;

  // frame status codes, the lowest failing code wins
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_START = 3'd2,
    ST_BAD_END   = 3'd3,
    ST_LEN_MISM  = 3'd4,
    ST_CRC_MISM  = 3'd5,
    ST_OVERSIZE  = 3'd6
  } ufc_status_e;

  // one frame report
  typedef struct packed {
    ufc_status_e status;
    logic [7:0]  packet_kind;
    logic [15:0] payload_length;
    logic [7:0]  first_payload;
    logic [31:0] computed_check;
  } ufc_result_t;

  // one byte through the crc, eight shift steps
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  data);
    logic [31:0] crc;
    crc = crc_in ^ {data, 24'h0};
    for (int k = 0; k < 8; k++) begin
      crc = crc[31] ? ({crc[30:0], 1'b0} ^ CRC_POLY) : {crc[30:0], 1'b0};
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

/* sv/update_frame_checker.sv */
// ----------------------------------------------------------------------------
// update_frame_checker
// Byte-stream frame checker: header capture, crc-32 over the payload and
// one status report per frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel carries one frame byte per word (data_byte_i) with
//   frame_end_i set on the last byte. Output channel carries one report
//   word per frame: status, packet kind, declared length, first payload
//   byte and the crc computed over the payload.
//   Throughput is one byte per cycle while no final byte waits for the report
//   register. A byte is held in the input register and then folded into the
//   frame state, where the crc step (eight shift stages, unrolled) and the
//   status compare run; out_valid_o is registered and rises on the same edge
//   that folds the final byte into the frame state.
//   When the receiver stalls, the report register holds. Middle bytes keep
//   flowing; a final byte waits in the input register until the report
//   register frees up, and in_stall_o stays high while it waits.
//   Reset clears the frame state (crc to all ones, counters and fields to
//   zero) and sets the markers to 0xAA and 0xBB. Markers are written through
//   the cfg port; the user writes them between frames, unchecked by the block.
// ----------------------------------------------------------------------------
`default_nettype none

module update_frame_checker import ufc_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [7:0]           cfg_wdata_i,
  // byte input channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [7:0]           data_byte_i,
  input  wire logic                 frame_end_i,
  // report output channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [2:0]                status_o,
  output logic [7:0]                packet_kind_o,
  output logic [15:0]               payload_length_o,
  output logic [7:0]                first_payload_o,
  output logic [31:0]               computed_check_o
);

  logic [7:0]  start_mk_q, end_mk_q;
  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s1_last_q;
  logic        s1_fire;
  logic        out_free;
  logic        in_accept;
  logic        out_valid_q;
  ufc_result_t out_q;
  ufc_result_t result;

  // marker registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_mk_q <= START_MARKER_RST;
      end_mk_q   <= END_MARKER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_MARKER: start_mk_q <= cfg_wdata_i;
        CFG_END_MARKER:   end_mk_q   <= cfg_wdata_i;
        default:          start_mk_q <= start_mk_q;
      endcase
    end
  end

  // handshake: only a final byte needs room in the report register
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && (!s1_last_q || out_free);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= frame_end_i;
    end
  end

  // frame state and report logic
  ufc_frame_track #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_track (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (s1_fire),
    .byte_i         (s1_byte_q),
    .last_i         (s1_last_q),
    .start_marker_i (start_mk_q),
    .end_marker_i   (end_mk_q),
    .result_o       (result)
  );

  // report register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_q) begin
      out_q <= result;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign packet_kind_o    = out_q.packet_kind;
  assign payload_length_o = out_q.payload_length;
  assign first_payload_o  = out_q.first_payload;
  assign computed_check_o = out_q.computed_check;

  // stall only while a word is held
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input register");

  // middle bytes never stall
  a_middle_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_last_q) |-> !in_stall_o)
    else $error("middle byte stalled");

  // a processed final byte yields a report
  a_last_gives_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_last_q) |=> out_valid_q)
    else $error("final byte produced no report");

endmodule

`default_nettype wire

/* sv/ufc_frame_track.sv */
// ----------------------------------------------------------------------------
// ufc_frame_track
// Per-frame state: byte position, header fields, running and received crc.
// Forms the frame report on the final byte and clears for the next frame.
// ----------------------------------------------------------------------------
`default_nettype none

module ufc_frame_track import ufc_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic [7:0]  byte_i,
  input  wire logic        last_i,
  input  wire logic [7:0]  start_marker_i,
  input  wire logic [7:0]  end_marker_i,
  output ufc_result_t      result_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [31:0]      crc_q, crc_d;
  logic [31:0]      rx_q, rx_d;
  logic [7:0]       kind_q, kind_d;
  logic [15:0]      len_q, len_d;
  logic [7:0]       first_q, first_d;
  logic             start_good_q, start_good_d;

  logic [POS_W:0]   pos_ext;
  logic [POS_W:0]   pay_end;
  logic [POS_W:0]   rx_end;
  logic [POS_W:0]   expect_cnt;

  // place the byte by its position in the frame
  always_comb begin
    start_good_d = start_good_q;
    kind_d       = kind_q;
    len_d        = len_q;
    first_d      = first_q;
    crc_d        = crc_q;
    rx_d         = rx_q;
    pos_ext      = {1'b0, pos_q};
    pay_end      = {{(POS_W+1-16){1'b0}}, len_q} + (POS_W+1)'(4);
    rx_end       = pay_end + (POS_W+1)'(4);
    if (pos_q == POS_W'(0)) begin
      start_good_d = (byte_i == start_marker_i);
    end else if (pos_q == POS_W'(1)) begin
      kind_d = byte_i;
    end else if (pos_q == POS_W'(2)) begin
      len_d = {len_q[15:8], byte_i};
    end else if (pos_q == POS_W'(3)) begin
      len_d = {byte_i, len_q[7:0]};
    end else if (pos_ext < pay_end) begin
      if (pos_q == POS_W'(4)) begin
        first_d = byte_i;
      end
      crc_d = crc_byte(crc_q, byte_i);
    end else if (pos_ext < rx_end) begin
      rx_d = {byte_i, rx_q[31:8]};
    end
    pos_d = (pos_q == POS_LIMIT) ? pos_q : pos_q + POS_W'(1);
  end

  // status in priority order, from the updated state
  always_comb begin
    expect_cnt = {{(POS_W+1-16){1'b0}}, len_d} + (POS_W+1)'(MIN_FRAME_BYTES);
    if (pos_d < POS_W'(MIN_FRAME_BYTES)) begin
      result_o.status = ST_SHORT;
    end else if (!start_good_d) begin
      result_o.status = ST_BAD_START;
    end else if (byte_i != end_marker_i) begin
      result_o.status = ST_BAD_END;
    end else if ({1'b0, pos_d} != expect_cnt) begin
      result_o.status = ST_LEN_MISM;
    end else if (crc_d != rx_d) begin
      result_o.status = ST_CRC_MISM;
    end else if (pos_d > POS_W'(MAX_FRAME_BYTES)) begin
      result_o.status = ST_OVERSIZE;
    end else begin
      result_o.status = ST_OK;
    end
    result_o.packet_kind    = kind_d;
    result_o.payload_length = len_d;
    result_o.first_payload  = first_d;
    result_o.computed_check = crc_d;
  end

  // frame state, cleared after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      crc_q        <= CRC_INIT;
      rx_q         <= '0;
      kind_q       <= '0;
      len_q        <= '0;
      first_q      <= '0;
      start_good_q <= 1'b0;
    end else if (en_i) begin
      if (last_i) begin
        pos_q        <= '0;
        crc_q        <= CRC_INIT;
        rx_q         <= '0;
        kind_q       <= '0;
        len_q        <= '0;
        first_q      <= '0;
        start_good_q <= 1'b0;
      end else begin
        pos_q        <= pos_d;
        crc_q        <= crc_d;
        rx_q         <= rx_d;
        kind_q       <= kind_d;
        len_q        <= len_d;
        first_q      <= first_d;
        start_good_q <= start_good_d;
      end
    end
  end

  // a final byte leaves a fresh frame behind
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && last_i) |=> (pos_q == '0 && crc_q == CRC_INIT && !start_good_q))
    else $error("frame state not cleared after final byte");

  // a middle byte always leaves a nonzero position
  a_pos_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && !last_i) |=> (pos_q != '0))
    else $error("byte position did not advance");

  // without a byte the frame state holds
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> ($stable(pos_q) && $stable(crc_q) && $stable(len_q)))
    else $error("frame state changed without a byte");

endmodule

`default_nettype wire
